@@ src/dpir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpir_pkg
// Shared types and constants of the dew point ice risk classifier.
// ----------------------------------------------------------------------------
package dpir_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LN_W       = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_FREEZE_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMID_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEW_MARGIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_RISK_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_MAX    = 3'd5;

  typedef enum logic [1:0] {
    RISK_NONE  = 2'd0,
    RISK_LOW   = 2'd1,
    RISK_HIGH  = 2'd2,
    RISK_FAULT = 2'd3
  } risk_t;

  // one classified reading handed from front to back
  typedef struct packed {
    logic                   fault;
    logic signed [15:0]     surface_temp;
    logic [9:0]             air_humidity;
    logic signed [13:0]     air_temp;
    logic signed [LN_W-1:0] ln_rh;
  } op_t;

  typedef struct packed {
    logic signed [13:0] freeze_limit;
    logic [9:0]         humid_limit;
    logic [12:0]        dew_margin;
    logic signed [13:0] low_risk_limit;
  } back_cfg_t;

endpackage

@@ src/dpir_intf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpir_intf
// Valid/ready channels for sensor readings and risk results.
// ----------------------------------------------------------------------------
interface dpir_sensor_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] surface_temp;
  logic [9:0]         air_humidity;
  logic signed [13:0] air_temp;

  modport source (output valid, output surface_temp, output air_humidity,
                  output air_temp, input ready);
  modport sink   (input valid, input surface_temp, input air_humidity,
                  input air_temp, output ready);
endinterface

interface dpir_risk_if;
  logic               valid;
  logic               ready;
  logic [1:0]         risk_level;
  logic signed [14:0] dew_point;

  modport source (output valid, output risk_level, output dew_point, input ready);
  modport sink   (input valid, input risk_level, input dew_point, output ready);
endinterface

@@ src/dpir_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpir_front
// Accepts readings, flags sensor faults and looks up ln(RH) in the log ROM.
// ----------------------------------------------------------------------------
module dpir_front #(
  parameter int LN_TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  dpir_sensor_if.sink         sensor,
  input  logic signed [15:0]  surface_min,
  input  logic signed [15:0]  surface_max,
  output logic                op_valid,
  input  logic                op_ready,
  output dpir_pkg::op_t       op
);

  localparam int AW = $clog2(LN_TABLE_DEPTH);

  localparam logic [63:0] THIRD_Q30 = 64'd1073741824 / 64'd3;

  // shift and subtract quotient, only used while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    begin
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        r = {r[63:0], n[b]};
        if (r >= {1'b0, d}) begin
          r    = r - {1'b0, d};
          q[b] = 1'b1;
        end
      end
      return q;
    end
  endfunction

  function automatic logic [63:0] atanh2_q30(input logic [63:0] z);
    logic [63:0] z2;
    logic [63:0] t;
    logic [63:0] s;
    begin
      z2 = (z * z) >> 30;
      t  = z;
      s  = z;
      for (int k = 1; k <= 20; k++) begin
        t = (t * z2) >> 30;
        s = s + udiv64(t, 64'(2 * k + 1));
      end
      return s << 1;
    end
  endfunction

  localparam logic [63:0] LN2_Q30 = atanh2_q30(THIRD_Q30);

  function automatic logic [63:0] ln_q30(input logic [31:0] n);
    int          e;
    logic [63:0] p;
    logic [63:0] z;
    begin
      e = 0;
      for (int b = 1; b < 32; b++) begin
        if ((n >> b) != 0) e = b;
      end
      p = 64'd1 << e;
      z = udiv64((64'(n) - p) << 30, 64'(n) + p);
      return 64'(e) * LN2_Q30 + atanh2_q30(z);
    end
  endfunction

  localparam logic [63:0] LN_1000_Q30 = ln_q30(32'd1000);

  // ln(i/1000) in Q16, rounded half away from zero
  function automatic logic signed [dpir_pkg::LN_W-1:0] ln_entry(input int i);
    logic signed [63:0] d;
    logic [63:0]        mag;
    logic [63:0]        q;
    begin
      if (i == 0) return '0;
      d   = $signed(ln_q30(32'(i))) - $signed(LN_1000_Q30);
      mag = (d < 0) ? 64'(-d) : 64'(d);
      q   = (mag + 64'd8192) >> 14;
      return (d < 0) ? dpir_pkg::LN_W'(-$signed(q)) : dpir_pkg::LN_W'(q);
    end
  endfunction

  logic signed [dpir_pkg::LN_W-1:0] ln_rom [LN_TABLE_DEPTH];

  for (genvar i = 0; i < LN_TABLE_DEPTH; i++) begin : g_rom
    localparam logic signed [dpir_pkg::LN_W-1:0] ENTRY = ln_entry(i);
    assign ln_rom[i] = ENTRY;
  end

  logic          en;
  logic          fault;
  logic [12:0]   idx_wide;
  logic [AW-1:0] addr;

  assign en           = !op_valid || op_ready;
  assign sensor.ready = en;

  always_comb begin
    fault = (sensor.surface_temp < surface_min) ||
            (sensor.surface_temp > surface_max) ||
            (sensor.air_humidity == '0);
    // humidity codes past the table use its last entry
    idx_wide = (13'(sensor.air_humidity) >= 13'(LN_TABLE_DEPTH)) ?
               13'(LN_TABLE_DEPTH - 1) : 13'(sensor.air_humidity);
    addr = idx_wide[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (en) begin
      op_valid <= sensor.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op.fault        <= fault;
      op.surface_temp <= sensor.surface_temp;
      op.air_humidity <= sensor.air_humidity;
      op.air_temp     <= sensor.air_temp;
      op.ln_rh        <= ln_rom[addr];
    end
  end

endmodule

@@ src/dpir_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpir_queue
// Two-entry queue that decouples the front and back pipelines.
// ----------------------------------------------------------------------------
module dpir_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dpir_pkg::op_t in_op,
  output logic          out_valid,
  input  logic          out_ready,
  output dpir_pkg::op_t out_op
);

  dpir_pkg::op_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_op    = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_op;
  end

endmodule

@@ src/dpir_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpir_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module dpir_div #(
  parameter int NUM_W  = 40,
  parameter int DEN_W  = 22,
  parameter int Q_W    = 20,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [Q_W-1:0]    quo,
  output logic [SIDE_W-1:0] side_out
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic              vld [Q_W+1];
  logic [NUM_W-1:0]  rem [Q_W];
  logic [DEN_W-1:0]  dv  [Q_W];
  logic [Q_W-1:0]    qt  [Q_W+1];
  logic [SIDE_W-1:0] sd  [Q_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dv[0]  <= den;
      qt[0]  <= '0;
      sd[0]  <= side_in;
    end
  end

  for (genvar s = 1; s <= Q_W; s++) begin : g_stage
    logic [CW-1:0]  dsh;
    logic [CW-1:0]  rext;
    logic           ge;
    logic [Q_W-1:0] q_next;

    always_comb begin
      dsh    = CW'(dv[s-1]) << (Q_W - s);
      rext   = CW'(rem[s-1]);
      ge     = (rext >= dsh);
      q_next = qt[s-1];
      q_next[Q_W-s] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qt[s] <= q_next;
        sd[s] <= sd[s-1];
      end
    end

    if (s < Q_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s] <= ge ? NUM_W'(rext - dsh) : rem[s-1];
          dv[s]  <= dv[s-1];
        end
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quo       = qt[Q_W];
  assign side_out  = sd[Q_W];

endmodule

@@ src/dpir_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpir_back
// Magnus dew point pipeline with two dividers, saturation and risk grading.
// ----------------------------------------------------------------------------
module dpir_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                op_valid,
  output logic                op_ready,
  input  dpir_pkg::op_t       op,
  input  dpir_pkg::back_cfg_t cfg,
  dpir_risk_if.source         risk
);

  typedef struct packed {
    logic                             fault;
    logic signed [15:0]               surface_temp;
    logic [9:0]                       air_humidity;
    logic signed [dpir_pkg::LN_W-1:0] ln_rh;
    logic                             neg;
  } side1_t;

  typedef struct packed {
    logic               fault;
    logic signed [15:0] surface_temp;
    logic [9:0]         air_humidity;
    logic               neg;
  } side2_t;

  logic en;
  assign en       = !risk.valid || risk.ready;
  assign op_ready = en;

  // stage 1: numerator and denominator of the temperature term
  logic                             v1;
  logic                             f1;
  logic signed [15:0]               surf1;
  logic [9:0]                       hum1;
  logic signed [dpir_pkg::LN_W-1:0] ln1;
  logic signed [24:0]               p1;
  logic [21:0]                      den1;
  logic signed [22:0]               den1_c;

  assign den1_c = 23'sd2377000 + 23'(op.air_temp) * 23'sd100;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1    <= op.fault;
      surf1 <= op.surface_temp;
      hum1  <= op.air_humidity;
      ln1   <= op.ln_rh;
      p1    <= 25'(op.air_temp) * 25'sd1727;
      den1  <= den1_c[21:0];
    end
  end

  // divider 1: term A in Q16
  logic signed [24:0] abs1;
  logic [39:0]        mag1;
  side1_t             s1_in;
  side1_t             s1_out;
  logic               v2;
  logic [19:0]        q1;

  always_comb begin
    abs1  = p1[24] ? -p1 : p1;
    mag1  = {abs1[23:0], 16'b0} + 40'(den1 >> 1);
    s1_in = '{fault: f1, surface_temp: surf1, air_humidity: hum1, ln_rh: ln1,
              neg: p1[24]};
  end

  dpir_div #(.NUM_W(40), .DEN_W(22), .Q_W(20), .SIDE_W($bits(side1_t))) u_div_a (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .num       (mag1),
    .den       (den1),
    .side_in   (s1_in),
    .out_valid (v2),
    .quo       (q1),
    .side_out  (s1_out)
  );

  // stage 3: G = A + ln(RH)
  logic signed [20:0] qa;
  logic signed [20:0] a_term;
  logic signed [21:0] g_c;
  logic               v3;
  logic               f3;
  logic signed [15:0] surf3;
  logic [9:0]         hum3;
  logic signed [21:0] g3;

  always_comb begin
    qa     = $signed({1'b0, q1});
    a_term = s1_out.neg ? -qa : qa;
    g_c    = 22'(a_term) + 22'(s1_out.ln_rh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3    <= s1_out.fault;
      surf3 <= s1_out.surface_temp;
      hum3  <= s1_out.air_humidity;
      g3    <= g_c;
    end
  end

  // stage 4: dew point numerator and denominator
  logic signed [29:0] den2_c;
  logic               v4;
  logic               f4;
  logic signed [15:0] surf4;
  logic [9:0]         hum4;
  logic signed [43:0] num4;
  logic [27:0]        den4;

  assign den2_c = 30'sd113180672 - 30'(g3) * 30'sd100;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f4    <= f3;
      surf4 <= surf3;
      hum4  <= hum3;
      num4  <= 44'(g3) * 44'sd2377000;
      den4  <= den2_c[27:0];
    end
  end

  // divider 2: dew point in hundredths
  logic signed [43:0] abs2;
  logic [41:0]        mag2;
  side2_t             s2_in;
  side2_t             s2_out;
  logic               v5;
  logic [15:0]        q2;

  always_comb begin
    abs2  = num4[43] ? -num4 : num4;
    mag2  = abs2[41:0] + 42'(den4 >> 1);
    s2_in = '{fault: f4, surface_temp: surf4, air_humidity: hum4, neg: num4[43]};
  end

  dpir_div #(.NUM_W(42), .DEN_W(28), .Q_W(16), .SIDE_W($bits(side2_t))) u_div_dew (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .num       (mag2),
    .den       (den4),
    .side_in   (s2_in),
    .out_valid (v5),
    .quo       (q2),
    .side_out  (s2_out)
  );

  // saturation and classification
  logic signed [16:0] dq;
  logic signed [16:0] dew_raw;
  logic signed [14:0] dew_sat;
  logic signed [17:0] diff;
  logic               near_dew;
  dpir_pkg::risk_t    level;

  always_comb begin
    dq      = $signed({1'b0, q2});
    dew_raw = s2_out.neg ? -dq : dq;
    if (dew_raw < -17'sd15000) begin
      dew_sat = -15'sd15000;
    end else if (dew_raw > 17'sd8000) begin
      dew_sat = 15'sd8000;
    end else begin
      dew_sat = 15'(dew_raw);
    end
    diff     = 18'(s2_out.surface_temp) - 18'(dew_sat);
    near_dew = diff < $signed({5'b0, cfg.dew_margin});
    if (s2_out.fault) begin
      level = dpir_pkg::RISK_FAULT;
    end else if ((17'(s2_out.surface_temp) < 17'(cfg.freeze_limit)) &&
                 (s2_out.air_humidity > cfg.humid_limit) && near_dew) begin
      level = dpir_pkg::RISK_HIGH;
    end else if (17'(s2_out.surface_temp) < 17'(cfg.low_risk_limit)) begin
      level = dpir_pkg::RISK_LOW;
    end else begin
      level = dpir_pkg::RISK_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      risk.valid <= 1'b0;
    end else if (en) begin
      risk.valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      risk.risk_level <= level;
      risk.dew_point  <= s2_out.fault ? 15'sd0 : dew_sat;
    end
  end

endmodule

@@ src/dew_point_ice_risk_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dew_point_ice_risk_classifier
// Road icing risk from surface temperature, air temperature and humidity.
// ----------------------------------------------------------------------------
// Takes one reading per clock while the result output is not held, and returns
// one result per reading, in order. A reading passes through the front (fault
// check and ln ROM read), the two-entry queue and the back, which spends most of
// its pipeline in the two dividers that retire one quotient bit per stage (20 for
// the temperature term, 16 for the dew point). Configuration registers are written
// at any cycle with cfg_wr_en; change them only while no reading is in flight.
module dew_point_ice_risk_classifier #(
  parameter int LN_TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  dpir_sensor_if.sink                       sensor,
  dpir_risk_if.source                       risk,
  input  logic                              cfg_wr_en,
  input  logic [dpir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dpir_pkg::CFG_DATA_W-1:0]   cfg_data
);

  dpir_pkg::back_cfg_t back_cfg;
  logic signed [15:0]  surface_min;
  logic signed [15:0]  surface_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      back_cfg.freeze_limit   <= 14'sd0;
      back_cfg.humid_limit    <= 10'd700;
      back_cfg.dew_margin     <= 13'd300;
      back_cfg.low_risk_limit <= 14'sd100;
      surface_min             <= -16'sd10000;
      surface_max             <= 16'sd20000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dpir_pkg::CFG_FREEZE_LIMIT:   back_cfg.freeze_limit   <= cfg_data[13:0];
        dpir_pkg::CFG_HUMID_LIMIT:    back_cfg.humid_limit    <= cfg_data[9:0];
        dpir_pkg::CFG_DEW_MARGIN:     back_cfg.dew_margin     <= cfg_data[12:0];
        dpir_pkg::CFG_LOW_RISK_LIMIT: back_cfg.low_risk_limit <= cfg_data[13:0];
        dpir_pkg::CFG_SURFACE_MIN:    surface_min             <= cfg_data;
        dpir_pkg::CFG_SURFACE_MAX:    surface_max             <= cfg_data;
        default: ;
      endcase
    end
  end

  logic          f_valid;
  logic          f_ready;
  dpir_pkg::op_t f_op;
  logic          b_valid;
  logic          b_ready;
  dpir_pkg::op_t b_op;

  dpir_front #(.LN_TABLE_DEPTH(LN_TABLE_DEPTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .sensor      (sensor),
    .surface_min (surface_min),
    .surface_max (surface_max),
    .op_valid    (f_valid),
    .op_ready    (f_ready),
    .op          (f_op)
  );

  dpir_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_op     (f_op),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_op    (b_op)
  );

  dpir_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (b_valid),
    .op_ready (b_ready),
    .op       (b_op),
    .cfg      (back_cfg),
    .risk     (risk)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dew point ice risk classifier.
// ----------------------------------------------------------------------------
// Readings are queued by the stimulus process and offered by a driver with
// random gaps. A monitor predicts the dew point and risk class of every
// accepted reading and checks the results in order. The receiver stalls in
// random bursts and once holds off long enough to back the block up. The
// limit registers move through several settings between traffic phases.
module tb;

  localparam int LN_DEPTH = 1024;
  localparam logic [dpir_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam longint unsigned Q30 = 64'd1 << 30;
  localparam longint DEW_LO = -15000;
  localparam longint DEW_HI = 8000;

  typedef struct {
    logic signed [15:0] surf;
    logic [9:0]         hum;
    logic signed [13:0] ta;
  } reading_t;

  typedef struct {
    dpir_pkg::risk_t    level;
    logic signed [14:0] dew;
  } icing_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [dpir_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dpir_pkg::CFG_DATA_W-1:0] cfg_data;

  dpir_sensor_if sensor ();
  dpir_risk_if   risk ();

  dew_point_ice_risk_classifier #(.LN_TABLE_DEPTH(LN_DEPTH)) dut (
    .clk(clk), .rst(rst), .sensor(sensor), .risk(risk),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // limit registers as the block should hold them
  longint freeze_lim, humid_lim, margin, low_lim, surf_min, surf_max;
  int ln_table [LN_DEPTH];

  reading_t reading_q[$];
  icing_t   icing_q[$];
  int issued, accepted, errors;
  bit quiet;
  bit in_xfer;

  function automatic longint round_div(longint n, longint d);
    longint unsigned mag, q;
    mag = (n < 0) ? longint'(-n) : n;
    q = (mag + longint'(d) / 2) / longint'(d);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned atanh2(longint unsigned z);
    longint unsigned z2, t, s;
    z2 = (z * z) >> 30;
    t = z;
    s = z;
    for (int k = 1; k <= 20; k++) begin
      t = (t * z2) >> 30;
      s += t / (2 * k + 1);
    end
    return 2 * s;
  endfunction

  function automatic longint unsigned ln30(int unsigned n);
    int unsigned e;
    longint unsigned p, z;
    e = 0;
    while ((n >> (e + 1)) != 0) e++;
    p = 64'd1 << e;
    z = ((longint'(n) - p) << 30) / (longint'(n) + p);
    return e * atanh2(Q30 / 3) + atanh2(z);
  endfunction

  function automatic void fill_ln_table();
    longint unsigned base;
    base = ln30(1000);
    ln_table[0] = 0;
    for (int i = 1; i < LN_DEPTH; i++)
      ln_table[i] = int'(round_div(longint'(ln30(i)) - longint'(base), 16384));
  endfunction

  function automatic icing_t classify(reading_t r);
    icing_t res;
    longint surf, ta, g, den, dew;
    int idx;
    surf = r.surf;
    ta = r.ta;
    if (surf < surf_min || surf > surf_max || r.hum == 0) begin
      res.level = dpir_pkg::RISK_FAULT;
      res.dew = '0;
      return res;
    end
    idx = (r.hum >= LN_DEPTH) ? LN_DEPTH - 1 : int'(r.hum);
    g = round_div(1727 * ta * 65536, 100 * (23770 + ta)) + ln_table[idx];
    den = 64'sd1727 * 65536 - 100 * g;
    dew = (den <= 0) ? DEW_HI : round_div(64'sd2377000 * g, den);
    if (dew < DEW_LO) dew = DEW_LO;
    if (dew > DEW_HI) dew = DEW_HI;
    if (surf < freeze_lim && longint'(r.hum) > humid_lim && (surf - dew) < margin)
      res.level = dpir_pkg::RISK_HIGH;
    else if (surf < low_lim)
      res.level = dpir_pkg::RISK_LOW;
    else
      res.level = dpir_pkg::RISK_NONE;
    res.dew = dew[14:0];
    return res;
  endfunction

  // input side: capture transfers and queue their predicted results
  always @(posedge clk) begin
    reading_t r;
    in_xfer = 1'b0;
    if (!rst && sensor.valid && sensor.ready) begin
      r.surf = sensor.surface_temp;
      r.hum = sensor.air_humidity;
      r.ta = sensor.air_temp;
      icing_q.push_back(classify(r));
      accepted++;
      in_xfer = 1'b1;
    end
  end

  // driver
  int gap;
  always @(negedge clk) begin
    reading_t r;
    logic nv;
    nv = sensor.valid;
    if (rst) begin
      nv = 1'b0;
    end else if (!sensor.valid || in_xfer) begin
      nv = 1'b0;
      if (gap > 0) begin
        gap--;
      end else if (reading_q.size() > 0) begin
        r = reading_q.pop_front();
        sensor.surface_temp <= r.surf;
        sensor.air_humidity <= r.hum;
        sensor.air_temp <= r.ta;
        nv = 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 17);
      end
    end
    sensor.valid <= nv;
  end

  // receiver with random stalls and one long hold-off
  int stall;
  bit backed_up;
  always @(negedge clk) begin
    logic nr;
    nr = 1'b1;
    if (rst) begin
      nr = 1'b0;
    end else if (stall > 0) begin
      stall--;
      nr = 1'b0;
    end else if (!backed_up && accepted >= 200) begin
      backed_up = 1'b1;
      stall = 300;
      nr = 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall = $urandom_range(0, 16);
      nr = 1'b0;
    end
    risk.ready <= nr;
  end

  // result checker
  always @(posedge clk) begin
    icing_t want;
    if (!rst && risk.valid && risk.ready) begin
      if (icing_q.size() == 0) begin
        $error("result with nothing expected: risk_level %0d dew_point %0d",
               risk.risk_level, risk.dew_point);
        errors++;
      end else begin
        want = icing_q.pop_front();
        if (risk.risk_level !== want.level) begin
          $error("risk_level: expected %0d, actual %0d", want.level, risk.risk_level);
          errors++;
        end
        if (risk.dew_point !== want.dew) begin
          $error("dew_point: expected %0d, actual %0d", want.dew, risk.dew_point);
          errors++;
        end
      end
    end
  end

  task automatic add_reading(int s, int h, int t);
    reading_t r;
    r.surf = s[15:0];
    r.hum = h[9:0];
    r.ta = t[13:0];
    reading_q.push_back(r);
    issued++;
  endtask

  task automatic add_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)
        add_reading($urandom_range(0, 8000) - 4000, $urandom_range(1, 1000),
                    $urandom_range(0, 12000) - 4000);
      else if (pick < 8)
        add_reading($urandom_range(0, 1000) - 500, $urandom_range(600, 1000),
                    $urandom_range(0, 1000) - 500);
      else
        add_reading($urandom, $urandom, $urandom);
    end
  endtask

  task automatic set_reg(logic [dpir_pkg::CFG_IDX_W-1:0] idx, int value);
    logic [15:0] v;
    v = value[15:0];
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      dpir_pkg::CFG_FREEZE_LIMIT:   freeze_lim = longint'($signed(v[13:0]));
      dpir_pkg::CFG_HUMID_LIMIT:    humid_lim = v[9:0];
      dpir_pkg::CFG_DEW_MARGIN:     margin = v[12:0];
      dpir_pkg::CFG_LOW_RISK_LIMIT: low_lim = longint'($signed(v[13:0]));
      dpir_pkg::CFG_SURFACE_MIN:    surf_min = longint'($signed(v));
      dpir_pkg::CFG_SURFACE_MAX:    surf_max = longint'($signed(v));
      default: ;
    endcase
  endtask

  task automatic set_all(int fz, int hl, int dm, int ll, int smin, int smax);
    set_reg(dpir_pkg::CFG_FREEZE_LIMIT, fz);
    set_reg(dpir_pkg::CFG_HUMID_LIMIT, hl);
    set_reg(dpir_pkg::CFG_DEW_MARGIN, dm);
    set_reg(dpir_pkg::CFG_LOW_RISK_LIMIT, ll);
    set_reg(dpir_pkg::CFG_SURFACE_MIN, smin);
    set_reg(dpir_pkg::CFG_SURFACE_MAX, smax);
  endtask

  task automatic drain();
    wait (accepted == issued && icing_q.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sensor.valid = 1'b0;
    sensor.surface_temp = '0;
    sensor.air_humidity = '0;
    sensor.air_temp = '0;
    risk.ready = 1'b0;
    freeze_lim = 0;
    humid_lim = 700;
    margin = 300;
    low_lim = 100;
    surf_min = -10000;
    surf_max = 20000;
    fill_ln_table();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_all(0, 700, 300, 100, -10000, 20000);
    // window edges, humidity zero and past the table, temperature extremes
    add_reading(-10000, 500, 0);
    add_reading(-10001, 500, 0);
    add_reading(20000, 500, 0);
    add_reading(20001, 500, 0);
    add_reading(-32768, 500, 0);
    add_reading(32767, 500, 0);
    add_reading(0, 0, 2000);
    add_reading(0, 1, 2000);
    add_reading(0, 1000, 2000);
    add_reading(0, 1001, 2000);
    add_reading(0, 1023, 2000);
    add_reading(500, 500, -8192);
    add_reading(500, 500, 8191);
    add_reading(500, 1, -8192);
    add_reading(500, 1023, 8191);
    add_reading(500, 500, -4000);
    add_reading(500, 500, 8000);
    // high, low and no risk
    add_reading(-200, 950, -100);
    add_reading(-200, 500, -100);
    add_reading(50, 950, 100);
    add_reading(3000, 400, 2500);
    add_reading(-1, 701, 0);
    add_random(150);
    drain();

    set_all(5000, 0, 5000, -5000, -32768, 32767);
    add_random(120);
    drain();

    set_all(-5000, 1000, 0, 5000, -2000, 2000);
    add_random(120);
    drain();

    // inverted window faults everything
    set_reg(dpir_pkg::CFG_SURFACE_MIN, 100);
    set_reg(dpir_pkg::CFG_SURFACE_MAX, -100);
    add_random(30);
    drain();

    set_all($urandom_range(0, 10000) - 5000, $urandom_range(0, 1000),
            $urandom_range(0, 5000), $urandom_range(0, 10000) - 5000, -6000, 9000);
    set_reg(CFG_UNUSED_IDX, 16'h1234);
    add_random(150);
    drain();

    set_all(200, 600, 800, 300, -10000, 20000);
    add_random(80);
    wait (issued - accepted < 100);
    quiet = 1'b1;
    add_random(100);
    drain();
    repeat (40) @(posedge clk);

    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #3ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

@@ files.f @@
src/dpir_pkg.sv
src/dpir_intf.sv
src/dpir_front.sv
src/dpir_queue.sv
src/dpir_div.sv
src/dpir_back.sv
src/dew_point_ice_risk_classifier.sv
tb/tb.sv
